>>> hw/rtl/ghh_pkg.sv
// Shared types and constants for the gradient/hessian histogram block.
// No dependencies; used by ghh_ram and gradient_hessian_histogram.
package ghh_pkg;

  localparam int unsigned BIN_COUNT    = 256;
  localparam int unsigned MAX_FEATURES = 64;

  localparam int unsigned FEAT_W = 6;
  localparam int unsigned BIN_W  = 8;
  localparam int unsigned VAL_W  = 24;
  localparam int unsigned SUM_W  = 40;
  localparam int unsigned PAIR_W = 2 * SUM_W;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                     operation;
    logic [FEAT_W-1:0]       feature;
    logic [BIN_W-1:0]        bin;
    logic signed [VAL_W-1:0] gradient;
    logic signed [VAL_W-1:0] hessian;
  } in_t;

  typedef struct packed {
    logic [FEAT_W-1:0]       out_feature;
    logic [BIN_W-1:0]        out_bin;
    logic signed [SUM_W-1:0] gradient_sum;
    logic signed [SUM_W-1:0] hessian_sum;
  } out_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] grad;
    logic signed [SUM_W-1:0] hess;
  } pair_t;

endpackage

>>> hw/rtl/gradient_hessian_histogram.sv
// Top level of the gradient/hessian histogram block.
// Depends on ghh_pkg and ghh_ram.
//
// Usage:
//   Command channel: an item (accumulate or read-and-clear of one
//   feature/bin cell) is taken at a rising edge with start_i high and busy_o
//   low. Accumulate adds gradient/hessian to the cell with saturation at
//   40 bits; read returns both sums and zeroes the cell. Out-of-range
//   feature or bin: accumulate does nothing, read returns zero sums.
//   Result channel: result_valid_o strobes for one cycle per read; the
//   receiver cannot stall, so every strobe is a delivered beat.
//   Latency: the result of a read accepted at edge N is on the ports in the
//   cycle after edge N+1 (taken at edge N+2).
//   Throughput: one item per cycle. The sums live in one RAM with a one
//   cycle read; a read-modify-write pair per item, and a one-entry forward
//   of the last write covers back-to-back hits on the same cell.
//   Reset: after rst_ni releases, busy_o stays high for
//   MaxFeatures * BinCount cycles (16384 by default) while a sweep writes
//   zero into every cell; no items are taken during that time.
module gradient_hessian_histogram #(
  parameter int unsigned BinCount    = ghh_pkg::BIN_COUNT,
  parameter int unsigned MaxFeatures = ghh_pkg::MAX_FEATURES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ghh_pkg::in_t  in_i,
  output logic          busy_o,
  output logic          result_valid_o,
  output ghh_pkg::out_t result_o
);

  localparam int unsigned Depth = BinCount * MaxFeatures;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  function automatic logic signed [ghh_pkg::SUM_W-1:0] sat_add(
    input logic signed [ghh_pkg::SUM_W-1:0] acc,
    input logic signed [ghh_pkg::VAL_W-1:0] inc
  );
    logic signed [ghh_pkg::SUM_W:0] sum;
    logic signed [ghh_pkg::SUM_W-1:0] res;
    sum = {acc[ghh_pkg::SUM_W-1], acc}
        + {{(ghh_pkg::SUM_W + 1 - ghh_pkg::VAL_W){inc[ghh_pkg::VAL_W-1]}}, inc};
    if (sum[ghh_pkg::SUM_W] != sum[ghh_pkg::SUM_W-1]) begin
      res = sum[ghh_pkg::SUM_W] ? ghh_pkg::SUM_MIN : ghh_pkg::SUM_MAX;
    end else begin
      res = sum[ghh_pkg::SUM_W-1:0];
    end
    return res;
  endfunction

  // clearing sweep
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  // stage 1: item waiting on RAM read data
  logic                               s1_vld_q;
  ghh_pkg::op_e                       s1_op_q;
  logic                               s1_ok_q;
  logic [AddrW-1:0]                   s1_addr_q;
  logic [ghh_pkg::FEAT_W-1:0]         s1_feature_q;
  logic [ghh_pkg::BIN_W-1:0]          s1_bin_q;
  logic signed [ghh_pkg::VAL_W-1:0]   s1_grad_q;
  logic signed [ghh_pkg::VAL_W-1:0]   s1_hess_q;

  // last write-back, for forwarding
  logic             wr_vld_q;
  logic [AddrW-1:0] wr_addr_q;
  ghh_pkg::pair_t   wr_data_q;

  logic             res_vld_q;
  ghh_pkg::out_t    res_q;

  logic             accept;
  logic             in_ok;
  logic [AddrW-1:0] in_addr;
  logic             s1_we;
  logic             fwd_hit;
  logic [ghh_pkg::PAIR_W-1:0] rd_raw;
  ghh_pkg::pair_t   cur;
  ghh_pkg::pair_t   upd;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  ghh_pkg::pair_t   ram_wdata;

  assign busy_o = clr_busy_q;
  assign accept = start_i & ~clr_busy_q;

  always_comb begin
    in_ok = (32'(in_i.feature) < MaxFeatures) && (32'(in_i.bin) < BinCount);
    in_addr = '0;
    if (in_ok) begin
      in_addr = AddrW'(32'(in_i.feature) * BinCount + 32'(in_i.bin));
    end
  end

  assign s1_we   = s1_vld_q & s1_ok_q;
  assign fwd_hit = s1_vld_q & wr_vld_q & (wr_addr_q == s1_addr_q);

  always_comb begin
    cur = fwd_hit ? wr_data_q : ghh_pkg::pair_t'(rd_raw);
    if (s1_op_q == ghh_pkg::OP_READ) begin
      upd = '0;
    end else begin
      upd.grad = sat_add(cur.grad, s1_grad_q);
      upd.hess = sat_add(cur.hess, s1_hess_q);
    end
  end

  always_comb begin
    ram_we    = clr_busy_q | s1_we;
    ram_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
    ram_wdata = clr_busy_q ? '0 : upd;
  end

  ghh_ram #(
    .Depth (Depth),
    .Width (ghh_pkg::PAIR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (rd_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_vld_q   <= 1'b0;
      wr_vld_q   <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == AddrW'(Depth - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      s1_vld_q  <= accept;
      wr_vld_q  <= s1_we;
      res_vld_q <= s1_vld_q & (s1_op_q == ghh_pkg::OP_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q      <= in_i.operation;
      s1_ok_q      <= in_ok;
      s1_addr_q    <= in_addr;
      s1_feature_q <= in_i.feature;
      s1_bin_q     <= in_i.bin;
      s1_grad_q    <= in_i.gradient;
      s1_hess_q    <= in_i.hessian;
    end
    if (s1_we) begin
      wr_addr_q <= s1_addr_q;
      wr_data_q <= upd;
    end
    if (s1_vld_q) begin
      res_q.out_feature  <= s1_feature_q;
      res_q.out_bin      <= s1_bin_q;
      res_q.gradient_sum <= s1_ok_q ? cur.grad : '0;
      res_q.hessian_sum  <= s1_ok_q ? cur.hess : '0;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  // a result beat only follows a read item in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> $past(s1_vld_q && (s1_op_q == ghh_pkg::OP_READ)))
    else $error("result beat without a read item");

  // no item may be in flight while the clearing sweep owns the write port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s1_vld_q)
    else $error("item in flight during clearing sweep");

  // forwarding only from a write-back in the previous cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit |-> $past(s1_we))
    else $error("forward hit without a preceding write-back");
`endif

endmodule

>>> hw/rtl/ghh_ram.sv
// Simple dual-port RAM, one write and one registered read port.
// Depends on ghh_pkg for default sizes.
module ghh_ram #(
  parameter int unsigned Depth = ghh_pkg::BIN_COUNT * ghh_pkg::MAX_FEATURES,
  parameter int unsigned Width = ghh_pkg::PAIR_W,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
